@@ rtl/assert_macros.svh @@
// Shared assertion helpers for the parity rebuild block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define RPE_ASSERT_IMP(name, clk_s, rst_ns, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off while reset is asserted.
`define RPE_ASSERT_NXT(name, clk_s, rst_ns, ante, cons, msg) \
	name: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/rpe_pkg.sv @@
package rpe_pkg;

	localparam int COL_W  = 6;   // column_bits and erased_mask width
	localparam int DATA_W = 64;  // data_block width
	localparam int DISK_W = 3;   // disk_number width
	localparam int CFG_W  = 32;
	localparam int ADDR_W = 4;
	localparam int IDX_W  = 2;

	localparam int MAX_DISKS_DEF      = 6;
	localparam int MAX_BLOCK_BITS_DEF = 64;
	localparam int MIN_DISKS          = 2;

	localparam logic [2:0] DISK_COUNT_RST = 3'd5;
	localparam logic [6:0] BLOCK_BITS_RST = 7'd8;
	localparam logic       ODD_PARITY_RST = 1'b0;

	typedef enum logic [IDX_W-1:0] {
		REG_DISK_COUNT = 2'd0,
		REG_BLOCK_BITS = 2'd1,
		REG_ODD_PARITY = 2'd2
	} reg_idx_t;

	// control for one disk cell of the stripe row
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// control for one cell of the result chain
	typedef struct packed {
		logic load;
		logic shift;
	} chain_ctl_t;

	typedef struct packed {
		logic              valid;
		logic              last;
		logic              invalid;
		logic [DISK_W-1:0] disk;
		logic [DATA_W-1:0] data;
	} out_item_t;

endpackage

@@ rtl/rpe_disk_cell.sv @@
module rpe_disk_cell #(
	parameter int MaxBits = rpe_pkg::MAX_BLOCK_BITS_DEF,
	parameter int CntW    = $clog2(MaxBits + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rpe_pkg::cell_ctl_t ctl,
	input  logic               bit_in,
	input  logic [CntW-1:0]    pad,
	input  logic [MaxBits-1:0] mask,
	output logic [MaxBits-1:0] block
);

	logic [MaxBits-1:0] store_q;
	logic [MaxBits-1:0] shifted;

	// newest bit enters at the bottom; first bit ends up highest
	assign shifted = (store_q << 1) | MaxBits'(bit_in);
	// align a short stripe to the top of the used width, drop stale bits
	assign block   = (shifted << pad) & mask;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (ctl.clear) begin
			store_q <= '0;
		end else if (ctl.shift) begin
			store_q <= shifted;
		end
	end

endmodule

@@ rtl/rpe_out_cell.sv @@
module rpe_out_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  rpe_pkg::chain_ctl_t ctl,
	input  rpe_pkg::out_item_t  load_item,
	input  rpe_pkg::out_item_t  next_item,
	output rpe_pkg::out_item_t  item
);

	rpe_pkg::out_item_t item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (ctl.load) begin
			item_q <= load_item;
		end else if (ctl.shift) begin
			item_q <= next_item;
		end
	end

	assign item = item_q;

endmodule

@@ rtl/raid_parity_erasure_recovery.sv @@
// Parity check and single-erasure rebuild over a disk set, one bit column per item.
// Input stream (s_axis_*): one column per item; tdata carries the disk bits and the
// erasure mask, tlast marks the final column of the set.
// Output stream (m_axis_*): one item per data disk when a stripe closes, in disk
// order, skipping that stripe's parity disk; tuser carries disk number and the sticky
// invalid flag, tlast marks the final item of the set.
// APB port: disk_count at 0x0, block_bits at 0x4, odd_parity at 0x8.
// Throughput: one column per cycle while a stripe fills. The column that closes a
// stripe loads the result chain in the same cycle and is held off until the chain has
// drained the previous stripe. The first result of a stripe shows in the cycle after
// its closing column is accepted; the rest follow one per cycle while the receiver
// is ready.
// The result chain is the output register: a stalled receiver holds the head item and
// the chain, and only the closing column of the next stripe waits on it.
// Reset clears the stripe row, column counter, parity disk rotation, sticky flag and
// chain, and loads the register defaults (5 disks, 8 bits, even parity).
`include "assert_macros.svh"

module raid_parity_erasure_recovery #(
	parameter int MaxDisks = rpe_pkg::MAX_DISKS_DEF,
	parameter int MaxBits  = rpe_pkg::MAX_BLOCK_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [rpe_pkg::ADDR_W-1:0] paddr,
	input  logic [rpe_pkg::CFG_W-1:0]  pwdata,
	output logic [rpe_pkg::CFG_W-1:0]  prdata,
	output logic                       pready,
	// column input
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [15:0]                s_axis_tdata,  // [5:0] column_bits, [11:6] erased_mask
	input  logic                       s_axis_tlast,  // last_column
	// result output
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [63:0]                m_axis_tdata,  // [63:0] data_block
	output logic [3:0]                 m_axis_tuser,  // [2:0] disk_number, [3] set_invalid
	output logic                       m_axis_tlast   // last_of_set
);

	localparam int CntW  = $clog2(MaxBits + 1);
	localparam int DW    = $clog2(MaxDisks + 1);
	localparam int PW    = $clog2(MaxDisks);
	localparam int NCell = MaxDisks - 1;
	localparam int ColW  = rpe_pkg::COL_W;

	// configuration registers
	logic [2:0] disk_count_q;
	logic [6:0] block_bits_q;
	logic       odd_parity_q;

	// stripe state
	logic [CntW-1:0] cnt_q;
	logic [PW-1:0]   parity_q;
	logic            inv_q;

	logic                        cfg_wr;
	logic [rpe_pkg::IDX_W-1:0]   cfg_idx;
	logic [DW-1:0]               d_eff;
	logic [CntW-1:0]             s_eff;
	logic [CntW-1:0]             filled;
	logic [CntW-1:0]             pad;
	logic [MaxBits-1:0]          mask;
	logic [DW-1:0]               p_acc;
	logic [PW-1:0]               p_eff;
	logic [DW-1:0]               p_inc;
	logic [MaxDisks-1:0]         act_vec;
	logic [MaxDisks-1:0]         bit_vec;
	logic [MaxDisks-1:0]         er_vec;
	logic [MaxDisks-1:0]         store_bit;
	logic                        any_er;
	logic                        multi_er;
	logic                        xr;
	logic                        inv_next;
	logic                        in_acc;
	logic                        end_col;
	logic                        out_acc;
	logic [MaxBits-1:0]          blocks [MaxDisks];
	rpe_pkg::out_item_t          items  [NCell];
	rpe_pkg::out_item_t          loads  [NCell];

	//------------------------------------------------------------------
	// APB registers
	//------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[rpe_pkg::ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_count_q <= rpe_pkg::DISK_COUNT_RST;
			block_bits_q <= rpe_pkg::BLOCK_BITS_RST;
			odd_parity_q <= rpe_pkg::ODD_PARITY_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				rpe_pkg::REG_DISK_COUNT: disk_count_q <= pwdata[2:0];
				rpe_pkg::REG_BLOCK_BITS: block_bits_q <= pwdata[6:0];
				rpe_pkg::REG_ODD_PARITY: odd_parity_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			rpe_pkg::REG_DISK_COUNT: prdata = rpe_pkg::CFG_W'(disk_count_q);
			rpe_pkg::REG_BLOCK_BITS: prdata = rpe_pkg::CFG_W'(block_bits_q);
			rpe_pkg::REG_ODD_PARITY: prdata = rpe_pkg::CFG_W'(odd_parity_q);
			default:                 prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Clamp the registers to usable ranges
	//------------------------------------------------------------------
	always_comb begin
		if (int'(disk_count_q) < rpe_pkg::MIN_DISKS) begin
			d_eff = DW'(rpe_pkg::MIN_DISKS);
		end else if (int'(disk_count_q) > MaxDisks) begin
			d_eff = DW'(MaxDisks);
		end else begin
			d_eff = DW'(disk_count_q);
		end
	end

	always_comb begin
		if (block_bits_q == '0) begin
			s_eff = CntW'(1);
		end else if (int'(block_bits_q) > MaxBits) begin
			s_eff = CntW'(MaxBits);
		end else begin
			s_eff = CntW'(block_bits_q);
		end
	end

	// fold a stale parity disk back under the disk count; it stays below
	// MaxDisks and the count is at least two, so a few subtracts settle it
	always_comb begin
		p_acc = DW'(parity_q);
		for (int i = 0; i < MaxDisks / 2; i++) begin
			if (p_acc >= d_eff) begin
				p_acc = p_acc - d_eff;
			end
		end
	end

	assign p_eff = PW'(p_acc);
	assign p_inc = DW'(p_eff) + DW'(1);

	//------------------------------------------------------------------
	// Column check and rebuild
	//------------------------------------------------------------------
	genvar j;
	generate
		for (j = 0; j < MaxDisks; j++) begin : g_col
			assign act_vec[j] = DW'(j) < d_eff;
			if (j < ColW) begin : g_in
				assign bit_vec[j] = s_axis_tdata[j];
				assign er_vec[j]  = s_axis_tdata[ColW + j] & act_vec[j];
			end else begin : g_none
				assign bit_vec[j] = 1'b0;
				assign er_vec[j]  = 1'b0;
			end
		end
	endgenerate

	assign any_er   = |er_vec;
	assign multi_er = |(er_vec & (er_vec - MaxDisks'(1)));
	assign xr       = ^(bit_vec & act_vec & ~er_vec);

	// erased bits take the rebuilt value, or zero when the column is lost
	always_comb begin
		for (int i = 0; i < MaxDisks; i++) begin
			if (!er_vec[i]) begin
				store_bit[i] = bit_vec[i];
			end else if (multi_er) begin
				store_bit[i] = 1'b0;
			end else begin
				store_bit[i] = xr ^ odd_parity_q;
			end
		end
	end

	assign inv_next = inv_q | multi_er | (!any_er && (xr != odd_parity_q));

	//------------------------------------------------------------------
	// Stripe control
	//------------------------------------------------------------------
	assign filled  = cnt_q + CntW'(1);
	assign end_col = s_axis_tlast | (filled >= s_eff);
	assign pad     = (filled < s_eff) ? (s_eff - filled) : '0;
	assign mask    = ~({MaxBits{1'b1}} << s_eff);

	// the closing column waits until the chain has drained
	assign s_axis_tready = !items[0].valid || !end_col;
	assign in_acc        = s_axis_tvalid & s_axis_tready;
	assign out_acc       = m_axis_tvalid & m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			parity_q <= '0;
			inv_q    <= 1'b0;
		end else if (in_acc) begin
			if (!end_col) begin
				cnt_q <= filled;
				inv_q <= inv_next;
			end else begin
				cnt_q <= '0;
				if (s_axis_tlast) begin
					parity_q <= '0;
					inv_q    <= 1'b0;
				end else begin
					parity_q <= (p_inc >= d_eff) ? '0 : PW'(p_inc);
					inv_q    <= inv_next;
				end
			end
		end
	end

	//------------------------------------------------------------------
	// Stripe row: one cell per disk
	//------------------------------------------------------------------
	generate
		for (j = 0; j < MaxDisks; j++) begin : g_disk
			rpe_pkg::cell_ctl_t dctl;

			assign dctl.shift = in_acc & act_vec[j];
			assign dctl.clear = in_acc & end_col;

			rpe_disk_cell #(
				.MaxBits (MaxBits),
				.CntW    (CntW)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (dctl),
				.bit_in (store_bit[j]),
				.pad    (pad),
				.mask   (mask),
				.block  (blocks[j])
			);
		end
	endgenerate

	//------------------------------------------------------------------
	// Result chain: data disks packed from cell 0 up, head is the output
	//------------------------------------------------------------------
	genvar k;
	generate
		for (k = 0; k < NCell; k++) begin : g_out
			rpe_pkg::chain_ctl_t cctl;
			rpe_pkg::out_item_t  nxt;
			logic                below_p;

			// below the parity disk take disk k, from there on disk k+1
			assign below_p          = k < int'(p_eff);
			assign loads[k].valid   = DW'(k + 1) < d_eff;
			assign loads[k].last    = s_axis_tlast && (DW'(k + 2) == d_eff);
			assign loads[k].invalid = inv_next;
			assign loads[k].disk    = below_p ? rpe_pkg::DISK_W'(k) : rpe_pkg::DISK_W'(k + 1);
			assign loads[k].data    = below_p ? rpe_pkg::DATA_W'(blocks[k])
			                                  : rpe_pkg::DATA_W'(blocks[k + 1]);

			assign cctl.load  = in_acc & end_col;
			assign cctl.shift = out_acc;

			if (k == NCell - 1) begin : g_tail
				assign nxt = '0;
			end else begin : g_mid
				assign nxt = items[k + 1];
			end

			rpe_out_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (cctl),
				.load_item (loads[k]),
				.next_item (nxt),
				.item      (items[k])
			);
		end
	endgenerate

	assign m_axis_tvalid = items[0].valid;
	assign m_axis_tdata  = items[0].data;
	assign m_axis_tuser  = {items[0].invalid, items[0].disk};
	assign m_axis_tlast  = items[0].last;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	`RPE_ASSERT_IMP(a_load_into_empty, clk, arst_n, in_acc && end_col, !items[0].valid, "stripe closed over a busy result chain")
	`RPE_ASSERT_NXT(a_load_shows, clk, arst_n, in_acc && end_col, m_axis_tvalid, "closed stripe produced no result")
	`RPE_ASSERT_NXT(a_set_clears, clk, arst_n, in_acc && s_axis_tlast, (parity_q == '0) && !inv_q && (cnt_q == '0), "set state not cleared after last column")
	`RPE_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q < CntW'(MaxBits), "column counter past block size")
	`RPE_ASSERT_IMP(a_parity_range, clk, arst_n, 1'b1, int'(parity_q) < MaxDisks, "parity disk out of range")

endmodule
